/* rtl/core/lpcb_pkg.sv */
// Shared types and constants for the LED pulse code blinker.
package lpcb_pkg;

   // Blink phase encoding, also driven on the phase output.
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ON   = 2'd1,
      PH_GAP  = 2'd2,
      PH_LONG = 2'd3
   } phase_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_ON_TICKS    = 2'd0;
   localparam logic [1:0] CSR_LONG_TICKS  = 2'd1;
   localparam logic [1:0] CSR_BAT_PULSES  = 2'd2;

   // Register reset values.
   localparam logic [15:0] ON_TICKS_RESET   = 16'd200;
   localparam logic [15:0] LONG_TICKS_RESET = 16'd3000;
   localparam logic [3:0]  BAT_PULSES_RESET = 4'd1;

   // Configuration seen by the blink logic.
   typedef struct packed {
      logic [15:0] on_ticks;
      logic [15:0] long_off_ticks;
      logic [3:0]  battery_low_pulses;
   } cfg_type;

   // One result of a tick.
   typedef struct packed {
      logic       led_on;
      logic [1:0] phase;
   } rsp_type;

endpackage

/* rtl/core/led_pulse_code_blinker_core.sv */
// Top level of the LED pulse code blinker.
// Usage: each request is one millisecond tick carrying a mode write flag,
// the requested pulse count and the battery status. Every request yields
// exactly one response with the LED level and blink phase after that tick.
// Requests are taken when req_valid is high and req_stall is low; responses
// leave when rsp_valid is high and rsp_stall is low.
// The response of an accepted request is registered in the result register,
// or in the skid register while a response waits. Throughput is one request
// per cycle while req_stall is low, set by the single pass of the mode,
// override and phase update between the state registers and result register.
// A skid register behind the result register lets a request enter while a
// response waits; req_stall rises only when both entries are occupied.
// Configuration writes on csr_write/csr_index/csr_data take effect at the
// next timer or pulse count load; write them only while the block is idle.
// Reset (synchronous, active high) sets the registers to on 200 ticks,
// long off 3000 ticks, one battery low pulse, and the LED to idle.
module led_pulse_code_blinker_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode_write,
   input  logic [3:0]  req_new_mode,
   input  logic        req_battery_ok,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_led_on,
   output logic [1:0]  rsp_phase,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   lpcb_pkg::cfg_type cfg;
   lpcb_pkg::rsp_type rsp_new;
   lpcb_pkg::rsp_type rsp_data;
   logic              accept;
   logic              full;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   lpcb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lpcb_step u_step (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .accept     (accept),
      .mode_write (req_mode_write),
      .new_mode   (req_new_mode),
      .battery_ok (req_battery_ok),
      .rsp        (rsp_new)
   );

   lpcb_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rsp_new   (rsp_new),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_led_on = rsp_data.led_on;
   assign rsp_phase  = rsp_data.phase;

endmodule

/* rtl/core/lpcb_csr.sv */
// Configuration registers of the LED pulse code blinker.
module lpcb_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_data,
   output lpcb_pkg::cfg_type    cfg
);

   lpcb_pkg::cfg_type cfg_ff;
   lpcb_pkg::cfg_type cfg_in;

   // Decode a write into the addressed register; other indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            lpcb_pkg::CSR_ON_TICKS:   cfg_in.on_ticks = csr_data;
            lpcb_pkg::CSR_LONG_TICKS: cfg_in.long_off_ticks = csr_data;
            lpcb_pkg::CSR_BAT_PULSES: cfg_in.battery_low_pulses = csr_data[3:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.on_ticks           <= lpcb_pkg::ON_TICKS_RESET;
         cfg_ff.long_off_ticks     <= lpcb_pkg::LONG_TICKS_RESET;
         cfg_ff.battery_low_pulses <= lpcb_pkg::BAT_PULSES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/lpcb_step.sv */
// Blink state and the per-tick update of mode, override, phase and timer.
module lpcb_step (
   input  logic                 clock,
   input  logic                 reset,
   input  lpcb_pkg::cfg_type    cfg,
   input  logic                 accept,
   input  logic                 mode_write,
   input  logic [3:0]           new_mode,
   input  logic                 battery_ok,
   output lpcb_pkg::rsp_type    rsp
);

   lpcb_pkg::phase_type phase_ff, phase_in;
   logic [15:0]         timer_ff, timer_in;
   logic [3:0]          pulses_ff, pulses_in;
   logic [3:0]          cur_mode_ff, cur_mode_in;
   logic [3:0]          saved_mode_ff, saved_mode_in;
   logic                override_ff, override_in;

   logic [3:0]  mode_wr;
   logic [3:0]  saved_wr;
   logic        expired;
   logic [15:0] timer_dec;

   // Mode write goes to the saved mode while the battery override is active.
   always_comb begin
      mode_wr  = (mode_write && !override_ff) ? new_mode : cur_mode_ff;
      saved_wr = (mode_write && override_ff) ? new_mode : saved_mode_ff;
   end

   // Battery override: enter on low battery, restore the saved mode on recovery.
   always_comb begin
      cur_mode_in   = mode_wr;
      saved_mode_in = saved_wr;
      override_in   = override_ff;
      if (!battery_ok) begin
         if (!override_ff) begin
            saved_mode_in = mode_wr;
            cur_mode_in   = cfg.battery_low_pulses;
            override_in   = 1'b1;
         end
      end else if (override_ff) begin
         cur_mode_in = saved_wr;
         override_in = 1'b0;
      end
   end

   // Timer expires when it reaches zero on this tick or is already zero.
   assign expired   = (timer_ff <= 16'd1);
   assign timer_dec = timer_ff - 16'd1;

   // Phase sequencing; a cycle start reloads from the updated mode.
   always_comb begin
      phase_in  = phase_ff;
      timer_in  = expired ? 16'd0 : timer_dec;
      pulses_in = pulses_ff;
      case (phase_ff)
         lpcb_pkg::PH_IDLE,
         lpcb_pkg::PH_LONG: begin
            if (phase_ff == lpcb_pkg::PH_IDLE || expired) begin
               if (cur_mode_in == 4'd0) begin
                  phase_in  = lpcb_pkg::PH_IDLE;
                  timer_in  = 16'd0;
                  pulses_in = 4'd0;
               end else begin
                  phase_in  = lpcb_pkg::PH_ON;
                  timer_in  = cfg.on_ticks;
                  pulses_in = cur_mode_in;
               end
            end
         end
         lpcb_pkg::PH_ON: begin
            if (expired) begin
               if (pulses_ff <= 4'd1) begin
                  pulses_in = 4'd0;
                  phase_in  = lpcb_pkg::PH_LONG;
                  timer_in  = cfg.long_off_ticks;
               end else begin
                  pulses_in = pulses_ff - 4'd1;
                  phase_in  = lpcb_pkg::PH_GAP;
                  timer_in  = cfg.on_ticks;
               end
            end
         end
         lpcb_pkg::PH_GAP: begin
            if (expired) begin
               phase_in = lpcb_pkg::PH_ON;
               timer_in = cfg.on_ticks;
            end
         end
         default: phase_in = lpcb_pkg::PH_IDLE;
      endcase
   end

   // State advances once per accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= lpcb_pkg::PH_IDLE;
         timer_ff      <= 16'd0;
         pulses_ff     <= 4'd0;
         cur_mode_ff   <= 4'd0;
         saved_mode_ff <= 4'd0;
         override_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         timer_ff      <= timer_in;
         pulses_ff     <= pulses_in;
         cur_mode_ff   <= cur_mode_in;
         saved_mode_ff <= saved_mode_in;
         override_ff   <= override_in;
      end
   end

   // Result of this tick, from the phase after the update.
   assign rsp.led_on = (phase_in == lpcb_pkg::PH_ON);
   assign rsp.phase  = phase_in;

`ifndef SYNTHESIS
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lpcb_pkg::PH_IDLE) |-> (timer_ff == 16'd0 && pulses_ff == 4'd0))
      else $error("idle phase with nonzero timer or pulse count");
   a_pulses_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lpcb_pkg::PH_ON || phase_ff == lpcb_pkg::PH_GAP) |-> (pulses_ff != 4'd0))
      else $error("pulse phase with zero pulses left");
   a_long_drained: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lpcb_pkg::PH_LONG) |-> (pulses_ff == 4'd0))
      else $error("long off phase with pulses left");
   a_override: assert property (@(posedge clock) disable iff (reset)
      accept |=> (override_ff == !$past(battery_ok)))
      else $error("override flag does not follow battery state");
`endif

endmodule

/* rtl/core/lpcb_out_buf.sv */
// Two-entry output buffer: result register plus skid register.
module lpcb_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  lpcb_pkg::rsp_type    rsp_new,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lpcb_pkg::rsp_type    rsp_data
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   lpcb_pkg::rsp_type out_data_ff, out_data_in;
   lpcb_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              take;

   assign take = out_valid_ff && !rsp_stall;

   // Refill the result register from the skid entry first, then the new request.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
            if (accept) begin
               skid_data_in  = rsp_new;
               skid_valid_in = 1'b1;
            end
         end else begin
            out_valid_in = accept;
            out_data_in  = rsp_new;
         end
      end else if (accept) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = rsp_new;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = rsp_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTHESIS
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty result register");
`endif

endmodule
